// File: rtl/tss_pkg.sv
// Shared types, constants and the seven-segment decode for the temperature scanner.
package tss_pkg;

	// Field widths
	localparam int SAMPLE_W   = 10;
	localparam int TENTHS_W   = 13;
	localparam int INTERVAL_W = 8;
	localparam int CHANNEL_W  = 3;
	localparam int SEL_W      = 4;
	localparam int SEG_W      = 8;
	localparam int DIGIT_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL  = 2'd1;

	// Register reset values
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd100;
	localparam logic [CHANNEL_W-1:0]  CHANNEL_RESET  = 3'd7;

	// Item kinds
	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// Sample scaling: tenths = (sample * 625) >> 7
	localparam int SCALE_MUL   = 625;
	localparam int SCALE_SHIFT = 7;
	localparam int SCALE_PROD_W = SAMPLE_W + 10;

	// Reciprocal constants, exact for values below 5000
	localparam int RECIP_W     = 14;
	localparam int PROD_W      = TENTHS_W + RECIP_W;
	localparam int RECIP_DIV10   = 6554;  // >> 16
	localparam int RECIP_DIV100  = 5243;  // >> 19
	localparam int RECIP_DIV1000 = 8389;  // >> 23

	// Scan positions
	typedef enum logic [1:0] {
		POS_UNITS    = 2'd0,
		POS_TENS     = 2'd1,
		POS_HUNDREDS = 2'd2,
		POS_THOUSANDS = 2'd3
	} scan_pos_t;

	// One-hot digit enables
	localparam logic [SEL_W-1:0] SEL_UNITS     = 4'b1000;
	localparam logic [SEL_W-1:0] SEL_TENS      = 4'b0100;
	localparam logic [SEL_W-1:0] SEL_HUNDREDS  = 4'b0010;
	localparam logic [SEL_W-1:0] SEL_THOUSANDS = 4'b0001;

	localparam logic [SEG_W-1:0] DP_BIT = 8'h80;

	// Common-cathode segment code, a..g in bits 0..6
	function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/tss_item_if.sv
// Input channel: scan ticks and converter samples.
interface tss_item_if import tss_pkg::*;;
	logic                valid;
	logic                ready;
	logic                func;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output func, output sample, input ready);
	modport sink   (input valid, input func, input sample, output ready);
endinterface

// File: rtl/tss_result_if.sv
// Result channel: digit select, segments and conversion request.
interface tss_result_if import tss_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [SEL_W-1:0]     digit_select;
	logic [SEG_W-1:0]     segments;
	logic                 start_conversion;
	logic [CHANNEL_W-1:0] conversion_channel;

	modport source (output valid, output digit_select, output segments,
		output start_conversion, output conversion_channel, input ready);
	modport sink   (input valid, input digit_select, input segments,
		input start_conversion, input conversion_channel, output ready);
endinterface

// File: rtl/tss_cfg_if.sv
// Configuration write channel.
interface tss_cfg_if import tss_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/temperature_seven_segment_scanner.sv
// Top level: four-digit multiplexed seven-segment temperature scanner.
//
//   channel     dir  payload
//   item_in     in   func, sample
//   result_out  out  digit_select, segments, start_conversion, conversion_channel
//   cfg         in   index, data (write only, always ready)
//
// One item per cycle while the output is not stalled. A tick's result passes through
// the input register, the scale/divide stage and the digit/decode output register.
// A sample makes no result; it updates the stored temperature in stage two.
// Reset clears the scan, tick counter and temperature and loads interval 100,
// channel 7. A stalled output backs up stage by stage; bubbles are squeezed out.
module temperature_seven_segment_scanner import tss_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	tss_item_if.sink      item_in,
	tss_result_if.source  result_out,
	tss_cfg_if.sink       cfg
);

	// Config registers
	logic [INTERVAL_W-1:0] interval_q;
	logic [CHANNEL_W-1:0]  channel_q;

	// Block state
	scan_pos_t             scan_q;
	logic [INTERVAL_W-1:0] tick_q;
	logic [TENTHS_W-1:0]   tenths_q;

	// Stage 1: input register
	logic                valid_s1;
	logic                func_s1;
	logic [SAMPLE_W-1:0] sample_s1;

	// Stage 2: quotient and control of a tick
	logic                valid_s2;
	logic [TENTHS_W-1:0] quot_s2;
	logic [SEL_W-1:0]    sel_s2;
	logic                dp_s2;
	logic                start_s2;

	// Output register
	logic                 out_valid_q;
	logic [SEL_W-1:0]     out_sel_q;
	logic [SEG_W-1:0]     out_seg_q;
	logic                 out_start_q;
	logic [CHANNEL_W-1:0] out_chan_q;

	logic en_out, en_s2, en_s1;
	logic in_fire;

	// Stage enables, a stage loads when empty or when it drains
	assign en_out  = !out_valid_q || result_out.ready;
	assign en_s2   = !valid_s2 || en_out;
	assign en_s1   = !valid_s1 || en_s2;
	assign in_fire = item_in.valid && en_s1;

	assign item_in.ready = en_s1;
	assign cfg.ready     = 1'b1;

	// Config writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
			channel_q  <= CHANNEL_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_INTERVAL: interval_q <= cfg.data;
				REG_CHANNEL:  channel_q  <= cfg.data[CHANNEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1   <= item_in.func;
			sample_s1 <= item_in.sample;
		end
	end

	// Sample scaling to tenths of a degree
	logic [SCALE_PROD_W-1:0] scale_prod;
	assign scale_prod = SCALE_PROD_W'(sample_s1) * SCALE_PROD_W'(SCALE_MUL);

	// Divide the stored value so that the digit of this position is its last digit
	logic [RECIP_W-1:0]  recip;
	logic [PROD_W-1:0]   div_prod;
	logic [TENTHS_W-1:0] quot;
	logic [SEL_W-1:0]    sel;

	always_comb begin
		unique case (scan_q)
			POS_UNITS:     begin recip = RECIP_W'(1);             sel = SEL_UNITS;     end
			POS_TENS:      begin recip = RECIP_W'(RECIP_DIV10);   sel = SEL_TENS;      end
			POS_HUNDREDS:  begin recip = RECIP_W'(RECIP_DIV100);  sel = SEL_HUNDREDS;  end
			POS_THOUSANDS: begin recip = RECIP_W'(RECIP_DIV1000); sel = SEL_THOUSANDS; end
			default:       begin recip = RECIP_W'(1);             sel = SEL_UNITS;     end
		endcase
	end

	assign div_prod = PROD_W'(tenths_q) * PROD_W'(recip);

	always_comb begin
		unique case (scan_q)
			POS_UNITS:     quot = tenths_q;
			POS_TENS:      quot = TENTHS_W'(div_prod[PROD_W-1:16]);
			POS_HUNDREDS:  quot = TENTHS_W'(div_prod[PROD_W-1:19]);
			POS_THOUSANDS: quot = TENTHS_W'(div_prod[PROD_W-1:23]);
			default:       quot = tenths_q;
		endcase
	end

	logic s1_tick, s1_sample, tick_hit;
	assign s1_tick   = valid_s1 && en_s2 && (func_s1 == FUNC_TICK);
	assign s1_sample = valid_s1 && en_s2 && (func_s1 == FUNC_SAMPLE);
	assign tick_hit  = (tick_q == interval_q);

	// Stage 2: state update and tick control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			scan_q   <= POS_UNITS;
			tick_q   <= '0;
			tenths_q <= '0;
		end else begin
			if (en_s2) begin
				valid_s2 <= s1_tick;
			end
			if (s1_sample) begin
				tenths_q <= scale_prod[SCALE_SHIFT +: TENTHS_W];
			end
			if (s1_tick) begin
				scan_q <= scan_pos_t'(scan_q + 2'd1);
				tick_q <= tick_hit ? '0 : tick_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_tick) begin
			quot_s2  <= quot;
			sel_s2   <= sel;
			dp_s2    <= (scan_q == POS_TENS);
			start_s2 <= tick_hit;
		end
	end

	// Last decimal digit of the quotient: q - 10 * (q / 10)
	logic [PROD_W-1:0]   mod_prod;
	logic [TENTHS_W-1:0] q_div10;
	logic [TENTHS_W-1:0] q_rem;
	logic [SEG_W-1:0]    seg;

	assign mod_prod = PROD_W'(quot_s2) * PROD_W'(RECIP_DIV10);
	assign q_div10  = TENTHS_W'(mod_prod[PROD_W-1:16]);
	assign q_rem    = quot_s2 - ((q_div10 << 3) + (q_div10 << 1));
	assign seg      = seg_code(q_rem[DIGIT_W-1:0]) | (dp_s2 ? DP_BIT : '0);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			out_sel_q   <= sel_s2;
			out_seg_q   <= seg;
			out_start_q <= start_s2;
			out_chan_q  <= channel_q;
		end
	end

	assign result_out.valid              = out_valid_q;
	assign result_out.digit_select       = out_sel_q;
	assign result_out.segments           = out_seg_q;
	assign result_out.start_conversion   = out_start_q;
	assign result_out.conversion_channel = out_chan_q;

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the temperature scanner: predicts digit scans, checks results.
module tb_top;
	import tss_pkg::*;

	// Indexes past the two real registers, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic                 func;
		logic [SAMPLE_W-1:0]  sample;
	} scan_item_t;

	typedef struct packed {
		logic [SEL_W-1:0]     digit_select;
		logic [SEG_W-1:0]     segments;
		logic                 start_conversion;
		logic [CHANNEL_W-1:0] conversion_channel;
	} display_t;

	logic clk = 1'b0;
	logic arst_n;

	tss_item_if   item_if();
	tss_result_if result_if();
	tss_cfg_if    cfg_if();

	temperature_seven_segment_scanner uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (result_if),
		.cfg        (cfg_if)
	);

	// Scanner mirror
	logic [INTERVAL_W-1:0] interval_q;
	logic [CHANNEL_W-1:0]  channel_q;
	scan_pos_t             pos_q;
	logic [INTERVAL_W-1:0] tick_cnt_q;
	logic [TENTHS_W-1:0]   tenths_q;

	scan_item_t item_backlog[$];
	display_t   display_expect_q[$];

	int sender_idle_pct = 0;
	int stall_pct = 0;
	logic item_fire = 1'b0;

	int tick_items = 0;
	int sample_items = 0;
	int results_seen = 0;
	int requests_seen = 0;
	int cfg_writes = 0;
	int mismatches = 0;

	always #5 clk = ~clk;

	// Common-cathode glyphs, a..g in bits 0..6
	function automatic logic [SEG_W-1:0] digit_glyph(input int d);
		case (d)
			0: return 8'h3F;
			1: return 8'h06;
			2: return 8'h5B;
			3: return 8'h4F;
			4: return 8'h66;
			5: return 8'h6D;
			6: return 8'h7D;
			7: return 8'h07;
			8: return 8'h7F;
			default: return 8'h6F;
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// Update the mirror for one accepted item and queue the digit it shows
	task automatic advance_scanner(input logic func, input logic [SAMPLE_W-1:0] sample);
		logic [SAMPLE_W+9:0] prod;
		int digit;
		display_t shown;
		if (func == FUNC_SAMPLE) begin
			// tenths of a degree: sample * 625 / 128, rounded down
			prod = SCALE_PROD_W'(sample) * SCALE_PROD_W'(SCALE_MUL);
			tenths_q = prod[SAMPLE_W+9:7];
			sample_items++;
		end else begin
			case (pos_q)
				POS_UNITS: begin
					digit = tenths_q % 10;
					shown.digit_select = SEL_UNITS;
				end
				POS_TENS: begin
					digit = (tenths_q / 10) % 10;
					shown.digit_select = SEL_TENS;
				end
				POS_HUNDREDS: begin
					digit = (tenths_q / 100) % 10;
					shown.digit_select = SEL_HUNDREDS;
				end
				default: begin
					digit = (tenths_q / 1000) % 10;
					shown.digit_select = SEL_THOUSANDS;
				end
			endcase
			shown.segments = digit_glyph(digit);
			if (pos_q == POS_TENS)
				shown.segments = shown.segments | DP_BIT;
			pos_q = scan_pos_t'(pos_q + 2'd1);
			// counter keeps running past a lowered interval and wraps at 255
			if (tick_cnt_q == interval_q) begin
				shown.start_conversion = 1'b1;
				tick_cnt_q = '0;
			end else begin
				shown.start_conversion = 1'b0;
				tick_cnt_q = tick_cnt_q + 1'b1;
			end
			shown.conversion_channel = channel_q;
			display_expect_q.push_back(shown);
			tick_items++;
		end
	endtask

	// Input side: note accepted items and predict
	always @(posedge clk) begin
		item_fire <= arst_n && item_if.valid && item_if.ready;
		if (arst_n && item_if.valid && item_if.ready)
			advance_scanner(item_if.func, item_if.sample);
	end

	// Item driver, new item or gap once the current one is taken
	always @(negedge clk) begin : item_drive
		scan_item_t nxt;
		if (!arst_n) begin
			item_if.valid <= 1'b0;
		end else if (!item_if.valid || item_fire) begin
			if (item_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				nxt = item_backlog.pop_front();
				item_if.valid <= 1'b1;
				item_if.func <= nxt.func;
				item_if.sample <= nxt.sample;
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		result_if.ready <= $urandom_range(99) >= stall_pct;
	end

	// Result check against the oldest prediction
	always @(posedge clk) begin : result_check
		display_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			results_seen++;
			if (result_if.start_conversion)
				requests_seen++;
			if (display_expect_q.size() == 0) begin
				flag_mismatch("result with nothing pending, digit_select", -1,
					int'(result_if.digit_select));
			end else begin
				want = display_expect_q.pop_front();
				if (result_if.digit_select !== want.digit_select)
					flag_mismatch("digit_select", int'(want.digit_select),
						int'(result_if.digit_select));
				if (result_if.segments !== want.segments)
					flag_mismatch("segments", int'(want.segments), int'(result_if.segments));
				if (result_if.start_conversion !== want.start_conversion)
					flag_mismatch("start_conversion", int'(want.start_conversion),
						int'(result_if.start_conversion));
				if (result_if.conversion_channel !== want.conversion_channel)
					flag_mismatch("conversion_channel", int'(want.conversion_channel),
						int'(result_if.conversion_channel));
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		if (idx == REG_INTERVAL)
			interval_q = val;
		else if (idx == REG_CHANNEL)
			channel_q = val[CHANNEL_W-1:0];
		cfg_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic push_item(input logic func, input logic [SAMPLE_W-1:0] sample);
		scan_item_t it;
		it.func = func;
		it.sample = sample;
		item_backlog.push_back(it);
	endtask

	task automatic push_ticks(input int n);
		repeat (n)
			push_item(FUNC_TICK, '0);
	endtask

	// Mostly ticks, some samples with a bias to the range ends
	task automatic push_random(input int n);
		logic [SAMPLE_W-1:0] s;
		repeat (n) begin
			if ($urandom_range(99) < 20) begin
				if ($urandom_range(9) == 0)
					s = $urandom_range(1) ? '1 : '0;
				else
					s = SAMPLE_W'($urandom_range(1023));
				push_item(FUNC_SAMPLE, s);
			end else begin
				push_item(FUNC_TICK, SAMPLE_W'($urandom_range(1023)));
			end
		end
	endtask

	// Wait until everything sent has drained and every prediction is checked, then add a tail
	task automatic settle();
		while (item_backlog.size() != 0 || item_if.valid || display_expect_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
	endtask

	task automatic run_phase(input logic [INTERVAL_W-1:0] interval,
		input logic [CHANNEL_W-1:0] channel, input int idle, input int stall, input int n);
		write_reg(REG_INTERVAL, interval);
		write_reg(REG_CHANNEL, {{(CFG_DATA_W-CHANNEL_W){1'b0}}, channel});
		sender_idle_pct = idle;
		stall_pct = stall;
		push_random(n);
		settle();
	endtask

	initial begin
		#2_000_000;
		$display("Timeout with %0d results still pending", display_expect_q.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.func = FUNC_TICK;
		item_if.sample = '0;
		result_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_INTERVAL;
		cfg_if.data = '0;
		interval_q = INTERVAL_RESET;
		channel_q = CHANNEL_RESET;
		pos_q = POS_UNITS;
		tick_cnt_q = '0;
		tenths_q = '0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// writes past the register map are dropped
		write_reg(REG_SPARE_LO, 8'hFF);
		write_reg(REG_SPARE_HI, 8'h00);

		// directed: reset value on all four digits, range ends, every glyph but the one for 1
		push_ticks(4);
		push_item(FUNC_SAMPLE, 10'd1023);
		push_ticks(4);
		push_item(FUNC_SAMPLE, 10'd578);
		push_ticks(4);
		push_item(FUNC_SAMPLE, 10'd159);
		push_ticks(4);
		push_item(FUNC_SAMPLE, 10'd682);
		push_ticks(4);
		push_item(FUNC_SAMPLE, 10'd0);
		settle();

		// interval lowered below the running count, must wrap through 255
		run_phase(8'd3, 3'd5, 0, 0, 450);
		// request on every tick
		run_phase(8'd0, 3'd0, 73, 0, 300);
		// longest interval, one request per 256 ticks
		run_phase(8'd255, 3'd7, 0, 73, 700);
		repeat (3)
			run_phase(INTERVAL_W'($urandom_range(255)), CHANNEL_W'($urandom_range(7)),
				9, 9, 117);

		$display("Checked %0d results from %0d ticks and %0d samples, %0d conversion requests",
			results_seen, tick_items, sample_items, requests_seen);
		$display("%0d register writes over six phases, %0d mismatches", cfg_writes, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
